@@ rtl/core/cbm_pkg.sv @@
`default_nettype none

package cbm_pkg;

  localparam int unsigned CYCLES_PER_STEP = 114;

  localparam logic [15:0] ADDR_PRG_8000 = 16'h8010;
  localparam logic [15:0] ADDR_PRG_A000 = 16'hA010;
  localparam logic [15:0] ADDR_MIRROR   = 16'h9400;
  localparam logic [15:0] DEC_MASK      = 16'hF00C;
  localparam logic [15:0] DEC_RELOAD_LO = 16'hF000;
  localparam logic [15:0] DEC_RELOAD_HI = 16'hF004;
  localparam logic [15:0] DEC_IRQ_MODE  = 16'hF008;
  localparam logic [3:0]  TOP_CHR_FIRST = 4'hB;
  localparam logic [3:0]  TOP_CHR_LAST  = 4'hE;
  localparam logic [11:0] PAGE_VRAM0    = 12'h088;
  localparam logic [11:0] PAGE_VRAM1    = 12'h0C8;
  localparam logic [7:0]  COUNT_MAX     = 8'hFF;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_PRG8 = 3'd1,
    KIND_PRGA = 3'd2,
    KIND_MIRR = 3'd3,
    KIND_CHR  = 3'd4,
    KIND_VRAM = 3'd5
  } kind_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [6:0]  cycles;
  } in_item_t;

  typedef struct packed {
    kind_t       update_kind;
    logic [2:0]  update_slot;
    logic [11:0] update_value;
    logic        irq_assert;
    logic        irq_release;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/cbm_core.sv @@
`default_nettype none

module cbm_core import cbm_pkg::*; #(
  parameter int unsigned STEP_CYCLES = CYCLES_PER_STEP
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en_i,
  input  wire in_item_t  item_i,
  output out_item_t      result_o
);

  logic [7:0] bank_r [8];
  logic [7:0] irq_reload_r, irq_reload_nxt;
  logic [7:0] irq_count_r, irq_count_nxt;
  logic [1:0] irq_mode_r, irq_mode_nxt;
  logic [7:0] irq_prescale_r, irq_prescale_nxt;
  logic       vram_select_r, vram_select_nxt;

  logic        bank_we;
  logic [2:0]  slot;
  logic [7:0]  bank_nxt;
  logic [15:0] dec;
  logic [3:0]  top;
  logic [3:0]  top_off;
  logic [11:0] page;
  logic [8:0]  acc;
  logic [8:0]  acc_sub;
  logic [8:0]  acc_fin;

  assign dec     = item_i.address & DEC_MASK;
  assign top     = dec[15:12];
  assign top_off = top - TOP_CHR_FIRST;
  assign slot    = {top_off[1:0], dec[3]};
  assign acc     = {1'b0, irq_prescale_r} + {2'b00, item_i.cycles};
  assign acc_sub = acc - 9'(STEP_CYCLES);

  always_comb begin
    result_o         = '0;
    result_o.update_kind = KIND_NONE;
    bank_we          = 1'b0;
    bank_nxt         = bank_r[slot];
    page             = '0;
    acc_fin          = acc;
    irq_reload_nxt   = irq_reload_r;
    irq_count_nxt    = irq_count_r;
    irq_mode_nxt     = irq_mode_r;
    irq_prescale_nxt = irq_prescale_r;
    vram_select_nxt  = vram_select_r;
    if (item_i.opcode == OP_TICK) begin
      if (irq_mode_r[1]) begin
        if (acc >= 9'(STEP_CYCLES)) begin
          acc_fin = acc_sub;
          if (irq_count_r == COUNT_MAX) begin
            irq_count_nxt       = irq_reload_r;
            irq_mode_nxt        = {irq_mode_r[0], irq_mode_r[0]};
            result_o.irq_assert = 1'b1;
          end else begin
            irq_count_nxt = irq_count_r + 8'd1;
          end
        end
        irq_prescale_nxt = acc_fin[8] ? 8'hFF : acc_fin[7:0];
      end
    end else if (item_i.address == ADDR_PRG_8000) begin
      result_o.update_kind  = KIND_PRG8;
      result_o.update_value = {4'h0, item_i.data};
    end else if (item_i.address == ADDR_PRG_A000) begin
      result_o.update_kind  = KIND_PRGA;
      result_o.update_value = {4'h0, item_i.data};
    end else if (item_i.address == ADDR_MIRROR) begin
      result_o.update_kind  = KIND_MIRR;
      result_o.update_value = {10'h000, item_i.data[1:0]};
    end else if (top inside {[TOP_CHR_FIRST:TOP_CHR_LAST]}) begin
      bank_we = 1'b1;
      if (dec[2]) begin
        bank_nxt = {item_i.data[3:0], bank_r[slot][3:0]};
        page     = {item_i.data[7:4], bank_nxt};
      end else begin
        bank_nxt = {bank_r[slot][7:4], item_i.data[3:0]};
        page     = {4'h0, bank_nxt};
      end
      // two magic pages steer the VRAM select instead of mapping a bank
      if (page == PAGE_VRAM0) begin
        vram_select_nxt       = 1'b0;
        result_o.update_kind  = KIND_VRAM;
        result_o.update_value = 12'd0;
      end else if (page == PAGE_VRAM1) begin
        vram_select_nxt       = 1'b1;
        result_o.update_kind  = KIND_VRAM;
        result_o.update_value = 12'd1;
      end else begin
        result_o.update_kind  = KIND_CHR;
        result_o.update_slot  = slot;
        result_o.update_value = page;
      end
    end else if (dec == DEC_RELOAD_LO) begin
      irq_reload_nxt = {irq_reload_r[7:4], item_i.data[3:0]};
    end else if (dec == DEC_RELOAD_HI) begin
      irq_reload_nxt = {item_i.data[3:0], irq_reload_r[3:0]};
    end else if (dec == DEC_IRQ_MODE) begin
      irq_mode_nxt         = item_i.data[1:0];
      result_o.irq_release = 1'b1;
      if (item_i.data[1]) begin
        irq_count_nxt    = irq_reload_r;
        irq_prescale_nxt = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= 8'(i);
      end
      irq_reload_r   <= '0;
      irq_count_r    <= '0;
      irq_mode_r     <= '0;
      irq_prescale_r <= '0;
      vram_select_r  <= 1'b0;
    end else if (en_i) begin
      if (bank_we) begin
        bank_r[slot] <= bank_nxt;
      end
      irq_reload_r   <= irq_reload_nxt;
      irq_count_r    <= irq_count_nxt;
      irq_mode_r     <= irq_mode_nxt;
      irq_prescale_r <= irq_prescale_nxt;
      vram_select_r  <= vram_select_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cartridge_bank_mapper_irq.sv @@
// Channel  Ports                              Payload
// input    in_valid / in_ready / in_data      in_item_t (opcode, address, data, cycles)
// output   out_valid / out_ready / out_data   out_item_t (kind, slot, value, irq pulses)
//
// Every transaction gives one result, registered in the input then the result register.
// One item per cycle unless stalled: input reg, one decode/counter pass, result reg.
// Mapper state changes as an item moves from the input to the result register.
// rst_n is synchronous: banks return to 0..7, IRQ state and VRAM select clear.
// A stalled result holds; in_ready drops only when both registers are full.
`default_nettype none

module cartridge_bank_mapper_irq import cbm_pkg::*; #(
  parameter int unsigned STEP_CYCLES = CYCLES_PER_STEP
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  cbm_core #(
    .STEP_CYCLES (STEP_CYCLES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (advance),
    .item_i   (s1_item_r),
    .result_o (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a register was free");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  a_irq_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.irq_assert && out_item_r.irq_release))
    else $error("IRQ assert and release in one result");

  a_slot_only_for_chr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.update_kind != KIND_CHR) |-> out_item_r.update_slot == 3'd0)
    else $error("slot set on a non pattern bank update");

endmodule

`default_nettype wire
